@@ rtl/rpta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rpta_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int DW = 40;
   localparam int KW = 31;

   localparam logic signed [DW-1:0] ANG_PI      = 40'sd3373259426;
   localparam logic signed [DW-1:0] ANG_TWO_PI  = 40'sd6746518853;
   localparam logic signed [DW-1:0] ANG_HALF_PI = 40'sd1686629713;

   function automatic logic signed [DW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [DW-1:0] v;
      case (idx)
         5'd0:  v = 40'sd843314856;
         5'd1:  v = 40'sd497837829;
         5'd2:  v = 40'sd263043836;
         5'd3:  v = 40'sd133525158;
         5'd4:  v = 40'sd67021686;
         5'd5:  v = 40'sd33543515;
         5'd6:  v = 40'sd16775850;
         5'd7:  v = 40'sd8388437;
         5'd8:  v = 40'sd4194282;
         5'd9:  v = 40'sd2097149;
         5'd10: v = 40'sd1048575;
         5'd11: v = 40'sd524287;
         5'd12: v = 40'sd262143;
         5'd13: v = 40'sd131071;
         5'd14: v = 40'sd65535;
         5'd15: v = 40'sd32767;
         5'd16: v = 40'sd16383;
         5'd17: v = 40'sd8191;
         5'd18: v = 40'sd4095;
         5'd19: v = 40'sd2047;
         5'd20: v = 40'sd1023;
         5'd21: v = 40'sd511;
         5'd22: v = 40'sd255;
         5'd23: v = 40'sd127;
         5'd24: v = 40'sd63;
         5'd25: v = 40'sd31;
         5'd26: v = 40'sd15;
         5'd27: v = 40'sd7;
         5'd28: v = 40'sd3;
         5'd29: v = 40'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] gain_g(input int steps);
      logic [63:0] p;
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      p = 64'd1 << 60;
      for (int i = 0; i < 64; i++) begin
         if (i < steps && 2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      n = p;
      res = '0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bit_v > n) begin
            bit_v = bit_v >> 2;
         end
      end
      for (int j = 0; j < 32; j++) begin
         if (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      if (res == 0) begin
         res = 64'd1;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ rtl/rotate_point_three_axis_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Rotates a Q16.16 point by up to three Q3.13 angles with one shared CORDIC
// shift-add unit and one 21x32 multiplier for gain correction. Pulse start
// while busy is low; the inputs are captured then. The result appears on the
// rsp_ ports for exactly one cycle with rsp_valid high and must be taken then:
// the block cannot be stalled. An item with all angles zero goes from its
// fetch straight to the result. Otherwise each step begins with a fetch,
// and a skipped rotation is passed over within it. A vectoring pass adds
// CORDIC_STEPS iterations and one low and high multiplier pass. A rotation
// pass adds angle reduction, CORDIC_STEPS iterations and two low and high
// multiplier passes, one per coordinate. One more fetch ends the item. An
// item with all three angles runs two vectoring and five rotation passes.
// The shared iteration unit sets the item time.
module rotate_point_three_axis_unit
   import rpta_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_x_in,
   input  wire logic signed [31:0] req_y_in,
   input  wire logic signed [31:0] req_z_in,
   input  wire logic signed [15:0] req_angle_lr,
   input  wire logic signed [15:0] req_angle_tb,
   input  wire logic signed [15:0] req_angle_cc,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_x_out,
   output logic signed [31:0]      rsp_y_out,
   output logic signed [31:0]      rsp_z_out
);

   localparam logic [63:0] G_VAL = gain_g(CORDIC_STEPS);
   localparam logic [KW-1:0] K_VAL = KW'(((64'd1 << 60) + G_VAL / 2) / G_VAL);
   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_RED, S_ITER, S_MLO, S_MHI
   } state_type;

   typedef enum logic [2:0] {
      M_NONE = 3'b000, M_CC = 3'b001, M_TB = 3'b010, M_TBCC = 3'b011,
      M_LR = 3'b100, M_LRCC = 3'b101, M_LRTB = 3'b110, M_ALL = 3'b111
   } mode_type;

   typedef enum logic [1:0] {K_END, K_VEC1, K_VEC2, K_ROT} kind_type;
   typedef enum logic [1:0] {P_LR, P_TB, P_CC} plane_type;
   typedef enum logic [2:0] {A_IN, A_T1, A_NT1, A_T2, A_NT2, A_R} asel_type;

   typedef struct packed {
      kind_type  kind;
      plane_type plane;
      asel_type  asel;
   } op_type;

   function automatic op_type mk(kind_type k, plane_type p, asel_type a);
      op_type o;
      o.kind = k;
      o.plane = p;
      o.asel = a;
      return o;
   endfunction

   function automatic op_type op_table(mode_type m, logic [2:0] i);
      op_type o;
      o = mk(K_END, P_LR, A_IN);
      case (m)
         M_LR:   if (i == 3'd0) o = mk(K_ROT, P_LR, A_IN);
         M_TB:   if (i == 3'd0) o = mk(K_ROT, P_TB, A_IN);
         M_CC:   if (i == 3'd0) o = mk(K_ROT, P_CC, A_IN);
         M_LRTB: begin
            case (i)
               3'd0: o = mk(K_VEC1, P_LR, A_IN);
               3'd1: o = mk(K_ROT, P_CC, A_T1);
               3'd2: o = mk(K_ROT, P_LR, A_R);
               3'd3: o = mk(K_ROT, P_CC, A_NT1);
               default: o = mk(K_END, P_LR, A_IN);
            endcase
         end
         M_LRCC: begin
            case (i)
               3'd0: o = mk(K_VEC1, P_LR, A_IN);
               3'd1: o = mk(K_ROT, P_TB, A_T1);
               3'd2: o = mk(K_ROT, P_LR, A_R);
               3'd3: o = mk(K_ROT, P_TB, A_NT1);
               default: o = mk(K_END, P_LR, A_IN);
            endcase
         end
         M_TBCC: begin
            case (i)
               3'd0: o = mk(K_VEC1, P_LR, A_IN);
               3'd1: o = mk(K_ROT, P_LR, A_T1);
               3'd2: o = mk(K_ROT, P_TB, A_R);
               3'd3: o = mk(K_ROT, P_LR, A_NT1);
               default: o = mk(K_END, P_LR, A_IN);
            endcase
         end
         M_ALL: begin
            case (i)
               3'd0: o = mk(K_VEC1, P_LR, A_IN);
               3'd1: o = mk(K_VEC2, P_LR, A_IN);
               3'd2: o = mk(K_ROT, P_CC, A_T1);
               3'd3: o = mk(K_ROT, P_LR, A_T2);
               3'd4: o = mk(K_ROT, P_TB, A_R);
               3'd5: o = mk(K_ROT, P_LR, A_NT2);
               3'd6: o = mk(K_ROT, P_CC, A_NT1);
               default: o = mk(K_END, P_LR, A_IN);
            endcase
         end
         default: o = mk(K_END, P_LR, A_IN);
      endcase
      return o;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [DW-1:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   mode_type mode_ff, mode_in;
   logic [2:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic mul_sel_ff, mul_sel_in;
   logic rneg_ff, rneg_in;
   logic signed [DW-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [DW-1:0] cx_ff, cx_in, cy_ff, cy_in, ang_ff, ang_in;
   logic signed [DW-1:0] va_ff, va_in, vb_ff, vb_in, vb2_ff, vb2_in;
   logic signed [DW-1:0] ain_ff, ain_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [DW-1:0] m_ff, m_in;
   logic signed [71:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;

   op_type op;
   logic signed [DW-1:0] lr40, tb40, cc40, alr, atb, tbs, ccs_l, ccs_t;
   logic signed [DW-1:0] phi, uc, vc, sx, sy, atn, rmag, mul_src, res;
   logic signed [20:0] mul_a;
   logic signed [52:0] prod;
   logic signed [71:0] sum;
   logic cw;

   assign op = op_table(mode_ff, idx_ff);

   assign lr40 = DW'(req_angle_lr);
   assign tb40 = DW'(req_angle_tb);
   assign cc40 = DW'(req_angle_cc);
   assign alr = req_angle_lr[15] ? -lr40 : lr40;
   assign atb = req_angle_tb[15] ? -tb40 : tb40;
   assign tbs = req_angle_lr[15] ? -tb40 : tb40;
   assign ccs_l = req_angle_lr[15] ? -cc40 : cc40;
   assign ccs_t = req_angle_tb[15] ? -cc40 : cc40;

   assign sx = cx_ff >>> cnt_ff;
   assign sy = cy_ff >>> cnt_ff;
   assign atn = atan_q30(5'(cnt_ff));
   assign cw = (op.kind == K_ROT) ? (ang_ff >= 0) : (cy_ff < 0);
   assign rmag = rneg_ff ? -(m_ff <<< 2) : (m_ff <<< 2);

   assign mul_src = mul_sel_ff ? cy_ff : cx_ff;
   assign mul_a = (state_ff == S_MHI) ? {mul_src[DW-1], mul_src[DW-1:20]}
                                      : {1'b0, mul_src[19:0]};
   assign prod = mul_a * $signed({1'b0, K_VAL});
   assign sum = acc_ff + (72'(prod) <<< 20) + 72'sd536870912;
   assign res = sum[69:30];

   always_comb begin
      case (op.asel)
         A_IN:    phi = ain_ff;
         A_T1:    phi = t1_ff;
         A_NT1:   phi = -t1_ff;
         A_T2:    phi = t2_ff;
         A_NT2:   phi = -t2_ff;
         A_R:     phi = rmag;
         default: phi = ain_ff;
      endcase
      case (op.plane)
         P_LR:    begin uc = px_ff; vc = pz_ff; end
         P_TB:    begin uc = py_ff; vc = pz_ff; end
         default: begin uc = px_ff; vc = py_ff; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      mul_sel_in = mul_sel_ff;
      rneg_in = rneg_ff;
      px_in = px_ff;
      py_in = py_ff;
      pz_in = pz_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      ang_in = ang_ff;
      va_in = va_ff;
      vb_in = vb_ff;
      vb2_in = vb2_ff;
      ain_in = ain_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      m_in = m_ff;
      acc_in = acc_ff;
      rsp_valid_in = 1'b0;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rz_in = rz_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = mode_type'({req_angle_lr != 0, req_angle_tb != 0,
                                     req_angle_cc != 0});
               idx_in = '0;
               px_in = DW'(req_x_in);
               py_in = DW'(req_y_in);
               pz_in = DW'(req_z_in);
               vb2_in = ccs_t <<< 15;
               case (mode_in)
                  M_LRTB: begin
                     va_in = alr <<< 15; vb_in = tbs <<< 15;
                  end
                  M_LRCC: begin
                     va_in = alr <<< 15; vb_in = -(ccs_l <<< 15);
                  end
                  M_TBCC: begin
                     va_in = atb <<< 15; vb_in = ccs_t <<< 15;
                  end
                  default: begin
                     va_in = alr <<< 15; vb_in = -(tbs <<< 15);
                  end
               endcase
               rneg_in = (mode_in == M_TBCC || mode_in == M_ALL) ?
                         req_angle_tb[15] : req_angle_lr[15];
               case (mode_in)
                  M_TB:    ain_in = tb40 <<< 17;
                  M_CC:    ain_in = cc40 <<< 17;
                  default: ain_in = lr40 <<< 17;
               endcase
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cnt_in = '0;
            mul_sel_in = 1'b0;
            case (op.kind)
               K_END: begin
                  rx_in = sat32(px_ff);
                  ry_in = sat32(py_ff);
                  rz_in = sat32(pz_ff);
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
               K_VEC1: begin
                  cx_in = va_ff; cy_in = vb_ff; ang_in = '0;
                  state_in = S_ITER;
               end
               K_VEC2: begin
                  cx_in = m_ff; cy_in = vb2_ff; ang_in = '0;
                  state_in = S_ITER;
               end
               default: begin
                  cx_in = vc; cy_in = uc; ang_in = phi;
                  if (phi == 0 || (vc == 0 && uc == 0)) begin
                     idx_in = idx_ff + 3'd1;
                  end else begin
                     state_in = S_RED;
                  end
               end
            endcase
         end
         S_RED: begin
            if (ang_ff > ANG_PI) begin
               ang_in = ang_ff - ANG_TWO_PI;
            end else if (ang_ff <= -ANG_PI) begin
               ang_in = ang_ff + ANG_TWO_PI;
            end else if (ang_ff > ANG_HALF_PI) begin
               cx_in = -cx_ff; cy_in = -cy_ff; ang_in = ang_ff - ANG_PI;
               state_in = S_ITER;
            end else if (ang_ff < -ANG_HALF_PI) begin
               cx_in = -cx_ff; cy_in = -cy_ff; ang_in = ang_ff + ANG_PI;
               state_in = S_ITER;
            end else begin
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            if (cw) begin
               cx_in = cx_ff - sy; cy_in = cy_ff + sx; ang_in = ang_ff - atn;
            end else begin
               cx_in = cx_ff + sy; cy_in = cy_ff - sx; ang_in = ang_ff + atn;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            acc_in = 72'(prod);
            state_in = S_MHI;
         end
         S_MHI: begin
            if (!mul_sel_ff) begin
               cx_in = res;
               if (op.kind == K_ROT) begin
                  mul_sel_in = 1'b1;
                  state_in = S_MLO;
               end else begin
                  m_in = res;
                  if (op.kind == K_VEC1) begin
                     t1_in = ang_ff;
                  end else begin
                     t2_in = ang_ff;
                  end
                  idx_in = idx_ff + 3'd1;
                  state_in = S_FETCH;
               end
            end else begin
               case (op.plane)
                  P_LR:    begin px_in = res; pz_in = cx_ff; end
                  P_TB:    begin py_in = res; pz_in = cx_ff; end
                  default: begin px_in = res; py_in = cx_ff; end
               endcase
               idx_in = idx_ff + 3'd1;
               state_in = S_FETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      mul_sel_ff <= mul_sel_in;
      rneg_ff <= rneg_in;
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      ang_ff <= ang_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
      vb2_ff <= vb2_in;
      ain_ff <= ain_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      m_ff <= m_in;
      acc_ff <= acc_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rz_ff <= rz_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_out = rx_ff;
   assign rsp_y_out = ry_ff;
   assign rsp_z_out = rz_ff;

endmodule
`default_nettype wire

@@ rtl/rpta_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rpta_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("transaction ended without a result");

endmodule

bind rotate_point_three_axis_unit rpta_checker u_rpta_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid)
);
`default_nettype wire

@@ dv/tb_rotate_point_three_axis_unit.sv @@
`timescale 1ns / 1ps
module tb_rotate_point_three_axis_unit;
   import rpta_pkg::*;

   localparam int STEPS = 16;
   localparam longint Q28_SCALE = 32768;
   localparam longint Q30_SCALE = 131072;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint TWO_PI_Q30 = 64'sd6746518853;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   class rotation_scoreboard;
      point_type expected_points[$];
      longint gain_corr;
      int     mismatches;
      int     checked;
      longint arctan_tab[STEPS];

      function new();
         logic [63:0] p, n, res, b;
         p = 64'd1 << 60;
         for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
         n = p;
         res = '0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         if (res == 0) res = 1;
         gain_corr = longint'(((64'd1 << 60) + res / 2) / res);
         arctan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                        131071, 65535, 32767};
         mismatches = 0;
         checked = 0;
      endfunction

      function longint apply_gain(longint v);
         return (v * gain_corr + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function void turn_plane(inout longint u, inout longint v, input longint phi);
         longint cx, cy, nx, ny;
         cx = v;
         cy = u;
         if (phi == 0 || (cx == 0 && cy == 0)) return;
         while (phi > PI_Q30) phi -= TWO_PI_Q30;
         while (phi <= -PI_Q30) phi += TWO_PI_Q30;
         if (phi > HALF_PI_Q30) begin
            cx = -cx; cy = -cy; phi -= PI_Q30;
         end else if (phi < -HALF_PI_Q30) begin
            cx = -cx; cy = -cy; phi += PI_Q30;
         end
         for (int i = 0; i < STEPS; i++) begin
            if (phi >= 0) begin
               nx = cx - (cy >>> i); ny = cy + (cx >>> i); phi -= arctan_tab[i];
            end else begin
               nx = cx + (cy >>> i); ny = cy - (cx >>> i); phi += arctan_tab[i];
            end
            cx = nx; cy = ny;
         end
         v = apply_gain(cx);
         u = apply_gain(cy);
      endfunction

      function longint align_angle(input longint a, input longint b, output longint mag);
         longint cx, cy, acc, nx, ny;
         cx = a; cy = b; acc = 0;
         for (int i = 0; i < STEPS; i++) begin
            if (cy >= 0) begin
               nx = cx + (cy >>> i); ny = cy - (cx >>> i); acc += arctan_tab[i];
            end else begin
               nx = cx - (cy >>> i); ny = cy + (cx >>> i); acc -= arctan_tab[i];
            end
            cx = nx; cy = ny;
         end
         mag = apply_gain(cx);
         return acc;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void note_request(logic signed [31:0] xi, logic signed [31:0] yi,
                                 logic signed [31:0] zi, logic signed [15:0] lr,
                                 logic signed [15:0] tb, logic signed [15:0] cc);
         longint x, y, z, a_lr, a_tb, a_cc, s_lr, s_tb, m1, m2, t1, t2, r;
         point_type pt;
         x = xi; y = yi; z = zi;
         a_lr = lr; a_tb = tb; a_cc = cc;
         s_lr = (a_lr < 0) ? -1 : 1;
         s_tb = (a_tb < 0) ? -1 : 1;
         if (a_lr != 0 && a_tb == 0 && a_cc == 0) begin
            turn_plane(x, z, a_lr * Q30_SCALE);
         end else if (a_lr == 0 && a_tb != 0 && a_cc == 0) begin
            turn_plane(y, z, a_tb * Q30_SCALE);
         end else if (a_lr == 0 && a_tb == 0 && a_cc != 0) begin
            turn_plane(x, y, a_cc * Q30_SCALE);
         end else if (a_lr != 0 && a_tb != 0 && a_cc == 0) begin
            t1 = align_angle(a_lr * s_lr * Q28_SCALE, s_lr * a_tb * Q28_SCALE, m1);
            r = s_lr * m1 * 4;
            turn_plane(x, y, t1);
            turn_plane(x, z, r);
            turn_plane(x, y, -t1);
         end else if (a_lr != 0 && a_tb == 0 && a_cc != 0) begin
            t1 = align_angle(a_lr * s_lr * Q28_SCALE, -s_lr * a_cc * Q28_SCALE, m1);
            r = s_lr * m1 * 4;
            turn_plane(y, z, t1);
            turn_plane(x, z, r);
            turn_plane(y, z, -t1);
         end else if (a_lr == 0 && a_tb != 0 && a_cc != 0) begin
            t1 = align_angle(a_tb * s_tb * Q28_SCALE, s_tb * a_cc * Q28_SCALE, m1);
            r = s_tb * m1 * 4;
            turn_plane(x, z, t1);
            turn_plane(y, z, r);
            turn_plane(x, z, -t1);
         end else if (a_lr != 0 && a_tb != 0 && a_cc != 0) begin
            t1 = align_angle(a_lr * s_lr * Q28_SCALE, -s_lr * a_tb * Q28_SCALE, m1);
            t2 = align_angle(m1, s_tb * a_cc * Q28_SCALE, m2);
            r = s_tb * m2 * 4;
            turn_plane(x, y, t1);
            turn_plane(x, z, t2);
            turn_plane(y, z, r);
            turn_plane(x, z, -t2);
            turn_plane(x, y, -t1);
         end
         pt.x = clamp32(x);
         pt.y = clamp32(y);
         pt.z = clamp32(z);
         expected_points.push_back(pt);
      endfunction

      task report(string what);
         $display("ERROR %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic signed [31:0] xo, logic signed [31:0] yo,
                        logic signed [31:0] zo);
         point_type pt;
         if (expected_points.size() == 0) begin
            report("unexpected result transaction");
            return;
         end
         pt = expected_points.pop_front();
         checked++;
         if (xo !== pt.x) report($sformatf("x_out %0d, want %0d", xo, pt.x));
         if (yo !== pt.y) report($sformatf("y_out %0d, want %0d", yo, pt.y));
         if (zo !== pt.z) report($sformatf("z_out %0d, want %0d", zo, pt.z));
      endtask

      function int outstanding();
         return expected_points.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_x_in = '0, req_y_in = '0, req_z_in = '0;
   logic signed [15:0] req_angle_lr = '0, req_angle_tb = '0, req_angle_cc = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_x_out, rsp_y_out, rsp_z_out;

   rotation_scoreboard sb = new();
   bit idle_enable = 1'b1;
   int combos_seen[8];

   always #2 clock = ~clock;

   rotate_point_three_axis_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_in(req_x_in), .req_y_in(req_y_in), .req_z_in(req_z_in),
      .req_angle_lr(req_angle_lr), .req_angle_tb(req_angle_tb),
      .req_angle_cc(req_angle_cc),
      .rsp_valid(rsp_valid), .rsp_x_out(rsp_x_out), .rsp_y_out(rsp_y_out),
      .rsp_z_out(rsp_z_out)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_x_out, rsp_y_out, rsp_z_out);
   end

   task send_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
                   logic signed [15:0] lr, logic signed [15:0] tb,
                   logic signed [15:0] cc);
      if (idle_enable && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_x_in <= x; req_y_in <= y; req_z_in <= z;
      req_angle_lr <= lr; req_angle_tb <= tb; req_angle_cc <= cc;
      do @(posedge clock); while (busy);
      sb.note_request(x, y, z, lr, tb, cc);
      combos_seen[{lr != 0, tb != 0, cc != 0}]++;
   endtask

   task drain();
      start <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   function logic signed [31:0] rand_coord();
      return $signed($urandom) >>> $urandom_range(0, 24);
   endfunction

   function logic signed [15:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return $signed(16'($urandom));
         default: return 16'($signed($urandom_range(0, 16383)) - 8192);
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_point(32'sd65536, -32'sd131072, 32'sd196608, 0, 0, 0);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh7fff, 0, 0);
      send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 16'sh8000, 0);
      send_point(32'sd100000, 32'sd200000, -32'sd300000, 0, 0, 16'sd1);
      send_point(32'sd100000, 32'sd200000, -32'sd300000, -16'sd1, 0, 0);
      send_point(0, 0, 0, 16'sd8192, 16'sd4096, 16'sd2048);
      send_point(0, 32'sd65536, 0, 16'sd12868, 0, 0);
      send_point(32'sd65536, 0, 0, 0, 16'sd16000, 0);
      send_point(32'sd65536, -32'sd65536, 0, 0, 0, -16'sd16000);
      send_point(32'sd65536, 32'sd65536, 32'sd65536, 16'sd25736, 0, 0);
      send_point(32'sd65536, 32'sd65536, 32'sd65536, 0, 0, -16'sd25736);
      send_point(32'sd65536, 32'sd65536, 32'sd65536, 16'sd4000, -16'sd3000, 0);
      send_point(-32'sd65536, 32'sd65536, 32'sd65536, -16'sd4000, 0, 16'sd3000);
      send_point(32'sd65536, -32'sd65536, 32'sd65536, 0, -16'sd4000, -16'sd3000);
      send_point(32'sd65536, 32'sd65536, -32'sd65536, 16'sd1000, 16'sd2000, 16'sd3000);
      send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 16'sh8000, 16'sh8000, 16'sh8000);
      send_point(32'sh7fffffff, 32'sh80000000, 0, -16'sd20000, 16'sd20000, 0);
      send_point(32'sh40000000, 32'sh40000000, 32'sh40000000, 16'sd6434, 0, 0);
      drain();
      for (int n = 0; n < 1330; n++) begin
         idle_enable = !(n >= 400 && n < 700);
         if (n == 900) drain();
         send_point(rand_coord(), rand_coord(), rand_coord(),
                    rand_angle(), rand_angle(), rand_angle());
      end
      drain();
      repeat (400) @(posedge clock);
      $display("Covered %0d results; angle mixes none/one/two/three: %0d/%0d/%0d/%0d",
               sb.checked, combos_seen[0],
               combos_seen[1] + combos_seen[2] + combos_seen[4],
               combos_seen[3] + combos_seen[5] + combos_seen[6], combos_seen[7]);
      if (sb.mismatches == 0) begin
         $display("tb_rotate_point_three_axis_unit passed");
      end else begin
         $display("tb_rotate_point_three_axis_unit failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_rotate_point_three_axis_unit failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rpta_pkg.sv
rtl/rotate_point_three_axis_unit.sv
rtl/rpta_checker.sv
dv/tb_rotate_point_three_axis_unit.sv
